// ===== rtl/kvts_pkg.sv =====
// ============================================================================
// kvts_pkg: shared definitions for the keyframe track sampler
// Sizes, the key record type, the sequencer state type and fraction constants.
// ============================================================================
`default_nettype none

package kvts_pkg;

    // Capacity of the key table.
    localparam int MAX_KEYS   = 64;
    localparam int KEY_IDX_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int KEY_CNT_W  = $clog2(MAX_KEYS + 1);
    localparam int SRCH_W     = KEY_CNT_W + 1;

    // Field widths fixed by the interface.
    localparam int DATA_W     = 32;
    localparam int IDX_FLD_W  = 6;
    localparam int CNT_FLD_W  = 7;

    // Fraction format: Q0.16 held in 17 bits, 1.0 is 65536.
    localparam int FRAC_BITS  = 16;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(1 << FRAC_BITS);
    localparam logic [FRAC_W-1:0] FRAC_ZERO = '0;
    localparam int DIV_CNT_W  = $clog2(FRAC_BITS);

    // Interpolation arithmetic widths.
    localparam int DIFF_W     = DATA_W + 1;
    localparam int PROD_W     = DIFF_W + FRAC_W + 1;
    localparam int NUM_COMP   = 3;

    typedef struct packed {
        logic        [DATA_W-1:0] time_val;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } key_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK0,
        ST_CHKL,
        ST_MID,
        ST_CMP1,
        ST_CMP2,
        ST_FETCH0,
        ST_FETCH1,
        ST_SEGEND,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } seq_state_t;

    // Function codes of an input item.
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/kvts_ifs.sv =====
// ============================================================================
// kvts_ifs: request and response channels of the keyframe track sampler
// Valid/ready channels; an item moves when valid and ready are both high.
// ============================================================================
`default_nettype none

interface kvts_req_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic [kvts_pkg::IDX_FLD_W-1:0]    key_index;
    logic [kvts_pkg::DATA_W-1:0]       key_time;
    logic signed [kvts_pkg::DATA_W-1:0] key_x;
    logic signed [kvts_pkg::DATA_W-1:0] key_y;
    logic signed [kvts_pkg::DATA_W-1:0] key_z;
    logic [kvts_pkg::DATA_W-1:0]       sample_time;

    modport source (
        output valid, func, key_index, key_time, key_x, key_y, key_z, sample_time,
        input  ready
    );
    modport sink (
        input  valid, func, key_index, key_time, key_x, key_y, key_z, sample_time,
        output ready
    );
endinterface

interface kvts_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [kvts_pkg::DATA_W-1:0] out_x;
    logic signed [kvts_pkg::DATA_W-1:0] out_y;
    logic signed [kvts_pkg::DATA_W-1:0] out_z;
    logic [kvts_pkg::IDX_FLD_W-1:0]    segment;

    modport source (
        output valid, out_x, out_y, out_z, segment,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, segment,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/kvts_key_mem.sv =====
// ============================================================================
// kvts_key_mem: key table storage
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module kvts_key_mem (
    input  wire logic                           clk,
    input  wire logic                           we,
    input  wire logic [kvts_pkg::KEY_IDX_W-1:0] waddr,
    input  wire kvts_pkg::key_t                 wdata,
    input  wire logic [kvts_pkg::KEY_IDX_W-1:0] raddr,
    output kvts_pkg::key_t                      rdata
);

    kvts_pkg::key_t mem [kvts_pkg::MAX_KEYS];
    kvts_pkg::key_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/kvts_frac_div.sv =====
// ============================================================================
// kvts_frac_div: radix-2 restoring divider for the segment fraction
// Forms floor((dividend << 16) / divisor), one quotient bit per cycle.
// ============================================================================
`default_nettype none

module kvts_frac_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [kvts_pkg::DATA_W-1:0]    dividend,
    input  wire logic [kvts_pkg::DATA_W-1:0]    divisor,
    output logic                                done,
    output logic [kvts_pkg::FRAC_BITS-1:0]      quotient
);

    // The dividend is always below the divisor, so the remainder fits
    // in the data width and the quotient in the fraction bits.
    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [kvts_pkg::DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [kvts_pkg::DATA_W-1:0]         rem_reg, rem_next;
    logic [kvts_pkg::DATA_W-1:0]         den_reg, den_next;
    logic [kvts_pkg::FRAC_BITS-1:0]      quo_reg, quo_next;
    logic [kvts_pkg::DATA_W:0]           shifted;
    logic [kvts_pkg::DATA_W:0]           trial;

    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        trial     = shifted - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = dividend;
            den_next  = divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (!trial[kvts_pkg::DATA_W])
            begin
                rem_next = trial[kvts_pkg::DATA_W-1:0];
                quo_next = {quo_reg[kvts_pkg::FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[kvts_pkg::DATA_W-1:0];
                quo_next = {quo_reg[kvts_pkg::FRAC_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + kvts_pkg::DIV_CNT_W'(1);
            if (cnt_reg == kvts_pkg::DIV_CNT_W'(kvts_pkg::FRAC_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/keyframe_vec3_track_sampler_unit.sv =====
// ============================================================================
// keyframe_vec3_track_sampler_unit: keyframe track sampler with linear blend
// Load item: written to the key table at its accepting edge, no result.
// Sample item: with one key, CHK0 then DONE; otherwise up to 2 range checks,
// binary-search probes of MID, CMP1 and, if needed, CMP2 (up to log2(MAX_KEYS)+1
// probes), FETCH0, FETCH1 and SEGEND, the divider only when the time lies
// strictly inside the segment, MUL and ACC per component, and DONE, which
// waits for a free output. Throughput: one sample at a time; the input is
// ready again as the result is registered. Search and serial divider set it.
// Reset: key_count returns to 1 and no result is pending; table is not cleared.
// ============================================================================
`default_nettype none

module keyframe_vec3_track_sampler_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [kvts_pkg::CNT_FLD_W-1:0] cfg_wr_data,
    kvts_req_if.sink                            req,
    kvts_rsp_if.source                          rsp
);

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    kvts_pkg::seq_state_t                state_reg, state_next;
    logic [kvts_pkg::CNT_FLD_W-1:0]      key_count_reg, key_count_next;

    logic [kvts_pkg::DATA_W-1:0]         t_reg, t_next;
    logic [kvts_pkg::KEY_CNT_W-1:0]      n_reg, n_next;
    logic signed [kvts_pkg::SRCH_W-1:0]  low_reg, low_next;
    logic signed [kvts_pkg::SRCH_W-1:0]  high_reg, high_next;
    logic signed [kvts_pkg::SRCH_W-1:0]  mid_reg, mid_next;
    logic [kvts_pkg::KEY_IDX_W-1:0]      seg_reg, seg_next;
    logic [kvts_pkg::DATA_W-1:0]         t0_reg, t0_next;
    logic signed [kvts_pkg::DATA_W-1:0]  s_reg [kvts_pkg::NUM_COMP];
    logic signed [kvts_pkg::DATA_W-1:0]  s_next [kvts_pkg::NUM_COMP];
    logic signed [kvts_pkg::DIFF_W-1:0]  d_reg [kvts_pkg::NUM_COMP];
    logic signed [kvts_pkg::DIFF_W-1:0]  d_next [kvts_pkg::NUM_COMP];
    logic signed [kvts_pkg::DATA_W-1:0]  res_reg [kvts_pkg::NUM_COMP];
    logic signed [kvts_pkg::DATA_W-1:0]  res_next [kvts_pkg::NUM_COMP];
    logic [kvts_pkg::FRAC_W-1:0]         frac_reg, frac_next;
    logic [1:0]                          comp_reg, comp_next;
    logic signed [kvts_pkg::PROD_W-1:0]  prod_reg, prod_next;

    logic                                out_valid_reg, out_valid_next;
    logic signed [kvts_pkg::DATA_W-1:0]  out_x_reg, out_x_next;
    logic signed [kvts_pkg::DATA_W-1:0]  out_y_reg, out_y_next;
    logic signed [kvts_pkg::DATA_W-1:0]  out_z_reg, out_z_next;
    logic [kvts_pkg::IDX_FLD_W-1:0]      out_seg_reg, out_seg_next;

    // ------------------------------------------------------------------
    // Derived values.
    // ------------------------------------------------------------------
    logic                                req_acc;
    logic                                out_free;
    logic [31:0]                         kc_ext;
    logic [31:0]                         eff_n;
    logic [31:0]                         idx_ext;
    logic [31:0]                         seg_ext;
    logic                                wr_en;
    logic [kvts_pkg::KEY_IDX_W-1:0]      wr_addr;
    kvts_pkg::key_t                      wr_key;
    logic [kvts_pkg::KEY_IDX_W-1:0]      rd_addr;
    kvts_pkg::key_t                      rd_key;
    logic [kvts_pkg::KEY_CNT_W-1:0]      n_minus1;
    logic [kvts_pkg::KEY_CNT_W-1:0]      n_minus2;
    logic signed [kvts_pkg::SRCH_W-1:0]  mid_calc;
    logic signed [kvts_pkg::SRCH_W-1:0]  mid_plus;
    logic signed [kvts_pkg::SRCH_W-1:0]  mid_minus;
    logic [kvts_pkg::KEY_IDX_W:0]        seg_plus1;
    logic                                div_start;
    logic                                div_done;
    logic [kvts_pkg::DATA_W-1:0]         div_dividend;
    logic [kvts_pkg::DATA_W-1:0]         div_divisor;
    logic [kvts_pkg::FRAC_BITS-1:0]      div_quotient;
    logic signed [kvts_pkg::DIFF_W-1:0]  mul_d;
    logic signed [kvts_pkg::DATA_W-1:0]  acc_s;
    logic signed [kvts_pkg::PROD_W-1:0]  prod_scaled;
    logic signed [kvts_pkg::PROD_W-1:0]  acc_sum;

    assign req_acc  = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // A key count of zero acts as one; a count above capacity is capped.
    assign kc_ext = 32'(key_count_reg);
    assign eff_n  = (kc_ext == 32'd0) ? 32'd1 :
                    ((kc_ext > 32'(kvts_pkg::MAX_KEYS)) ? 32'(kvts_pkg::MAX_KEYS) : kc_ext);

    // Loads go straight into the table on acceptance; a slot beyond
    // capacity is dropped.
    assign idx_ext  = 32'(req.key_index);
    assign wr_en    = req_acc && (req.func == kvts_pkg::FUNC_LOAD) &&
                      (idx_ext < 32'(kvts_pkg::MAX_KEYS));
    assign wr_addr  = idx_ext[kvts_pkg::KEY_IDX_W-1:0];
    assign wr_key   = '{time_val: req.key_time, x: req.key_x, y: req.key_y, z: req.key_z};

    assign n_minus1  = n_reg - kvts_pkg::KEY_CNT_W'(1);
    assign n_minus2  = n_reg - kvts_pkg::KEY_CNT_W'(2);
    assign mid_calc  = low_reg + ((high_reg - low_reg) >>> 1);
    assign mid_plus  = mid_reg + kvts_pkg::SRCH_W'(1);
    assign mid_minus = mid_reg - kvts_pkg::SRCH_W'(1);
    assign seg_plus1 = {1'b0, seg_reg} + (kvts_pkg::KEY_IDX_W + 1)'(1);
    assign seg_ext   = 32'(seg_reg);

    // The divider sees the segment end key straight from the table read.
    assign div_dividend = t_reg - t0_reg;
    assign div_divisor  = rd_key.time_val - t0_reg;

    // Shared multiply and accumulate for the three components. The
    // arithmetic shift floors toward minus infinity.
    assign mul_d       = d_reg[comp_reg];
    assign acc_s       = s_reg[comp_reg];
    assign prod_scaled = prod_reg >>> kvts_pkg::FRAC_BITS;
    assign acc_sum     = prod_scaled + kvts_pkg::PROD_W'(acc_s);

    kvts_key_mem u_key_mem (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_key),
        .raddr (rd_addr),
        .rdata (rd_key)
    );

    kvts_frac_div u_frac_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // ------------------------------------------------------------------
    // Next-state logic. A state that uses the table word gets the one read
    // in the previous cycle.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kvts_pkg::ST_IDLE:
            begin
                if (req_acc && (req.func == kvts_pkg::FUNC_SAMPLE))
                begin
                    state_next = kvts_pkg::ST_CHK0;
                end
            end
            kvts_pkg::ST_CHK0:
            begin
                if (n_reg == kvts_pkg::KEY_CNT_W'(1))
                begin
                    state_next = kvts_pkg::ST_DONE;
                end
                else if (t_reg <= rd_key.time_val)
                begin
                    state_next = kvts_pkg::ST_FETCH0;
                end
                else
                begin
                    state_next = kvts_pkg::ST_CHKL;
                end
            end
            kvts_pkg::ST_CHKL:
            begin
                if (t_reg >= rd_key.time_val)
                begin
                    state_next = kvts_pkg::ST_FETCH0;
                end
                else
                begin
                    state_next = kvts_pkg::ST_MID;
                end
            end
            kvts_pkg::ST_MID:
            begin
                if (low_reg > high_reg)
                begin
                    state_next = kvts_pkg::ST_FETCH0;
                end
                else
                begin
                    state_next = kvts_pkg::ST_CMP1;
                end
            end
            kvts_pkg::ST_CMP1:
            begin
                if (rd_key.time_val <= t_reg)
                begin
                    state_next = kvts_pkg::ST_CMP2;
                end
                else
                begin
                    state_next = kvts_pkg::ST_MID;
                end
            end
            kvts_pkg::ST_CMP2:
            begin
                if (t_reg < rd_key.time_val)
                begin
                    state_next = kvts_pkg::ST_FETCH0;
                end
                else
                begin
                    state_next = kvts_pkg::ST_MID;
                end
            end
            kvts_pkg::ST_FETCH0:
            begin
                state_next = kvts_pkg::ST_FETCH1;
            end
            kvts_pkg::ST_FETCH1:
            begin
                state_next = kvts_pkg::ST_SEGEND;
            end
            kvts_pkg::ST_SEGEND:
            begin
                if ((t_reg <= t0_reg) || (t_reg >= rd_key.time_val))
                begin
                    state_next = kvts_pkg::ST_MUL;
                end
                else
                begin
                    state_next = kvts_pkg::ST_DIV;
                end
            end
            kvts_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = kvts_pkg::ST_MUL;
                end
            end
            kvts_pkg::ST_MUL:
            begin
                state_next = kvts_pkg::ST_ACC;
            end
            kvts_pkg::ST_ACC:
            begin
                if (comp_reg == 2'(kvts_pkg::NUM_COMP - 1))
                begin
                    state_next = kvts_pkg::ST_DONE;
                end
                else
                begin
                    state_next = kvts_pkg::ST_MUL;
                end
            end
            kvts_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = kvts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kvts_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: handshake, table read address, divider start.
    // ------------------------------------------------------------------
    always_comb
    begin
        req.ready = 1'b0;
        rd_addr   = '0;
        div_start = 1'b0;
        unique case (state_reg)
            kvts_pkg::ST_IDLE:
            begin
                // Key 0 is read speculatively for the next sample.
                req.ready = 1'b1;
                rd_addr   = '0;
            end
            kvts_pkg::ST_CHK0:
            begin
                rd_addr = n_minus1[kvts_pkg::KEY_IDX_W-1:0];
            end
            kvts_pkg::ST_MID:
            begin
                rd_addr = mid_calc[kvts_pkg::KEY_IDX_W-1:0];
            end
            kvts_pkg::ST_CMP1:
            begin
                rd_addr = mid_plus[kvts_pkg::KEY_IDX_W-1:0];
            end
            kvts_pkg::ST_FETCH0:
            begin
                rd_addr = seg_reg;
            end
            kvts_pkg::ST_FETCH1:
            begin
                rd_addr = seg_plus1[kvts_pkg::KEY_IDX_W-1:0];
            end
            kvts_pkg::ST_SEGEND:
            begin
                div_start = (t_reg > t0_reg) && (t_reg < rd_key.time_val);
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values.
    // ------------------------------------------------------------------
    always_comb
    begin
        key_count_next = cfg_wr_en ? cfg_wr_data : key_count_reg;
        t_next         = t_reg;
        n_next         = n_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        mid_next       = mid_reg;
        seg_next       = seg_reg;
        t0_next        = t0_reg;
        s_next         = s_reg;
        d_next         = d_reg;
        res_next       = res_reg;
        frac_next      = frac_reg;
        comp_next      = comp_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_z_next     = out_z_reg;
        out_seg_next   = out_seg_reg;

        case (state_reg)
            kvts_pkg::ST_IDLE:
            begin
                if (req_acc)
                begin
                    t_next = req.sample_time;
                    n_next = eff_n[kvts_pkg::KEY_CNT_W-1:0];
                end
            end
            kvts_pkg::ST_CHK0:
            begin
                // With a single key its value goes out unchanged.
                seg_next    = '0;
                res_next[0] = rd_key.x;
                res_next[1] = rd_key.y;
                res_next[2] = rd_key.z;
            end
            kvts_pkg::ST_CHKL:
            begin
                seg_next  = n_minus2[kvts_pkg::KEY_IDX_W-1:0];
                low_next  = '0;
                high_next = kvts_pkg::SRCH_W'(n_minus1);
            end
            kvts_pkg::ST_MID:
            begin
                // An empty interval means the keys are out of order.
                mid_next = mid_calc;
                seg_next = '0;
            end
            kvts_pkg::ST_CMP1:
            begin
                // The upper bound moves only when the probed key lies past t.
                if (rd_key.time_val > t_reg)
                begin
                    high_next = mid_minus;
                end
            end
            kvts_pkg::ST_CMP2:
            begin
                seg_next = mid_reg[kvts_pkg::KEY_IDX_W-1:0];
                low_next = mid_plus;
            end
            kvts_pkg::ST_FETCH1:
            begin
                t0_next   = rd_key.time_val;
                s_next[0] = rd_key.x;
                s_next[1] = rd_key.y;
                s_next[2] = rd_key.z;
            end
            kvts_pkg::ST_SEGEND:
            begin
                d_next[0] = kvts_pkg::DIFF_W'(rd_key.x) - kvts_pkg::DIFF_W'(s_reg[0]);
                d_next[1] = kvts_pkg::DIFF_W'(rd_key.y) - kvts_pkg::DIFF_W'(s_reg[1]);
                d_next[2] = kvts_pkg::DIFF_W'(rd_key.z) - kvts_pkg::DIFF_W'(s_reg[2]);
                comp_next = '0;
                // At or before the segment start the fraction is zero; at or past
                // its end, including a degenerate segment, it is one.
                if (t_reg <= t0_reg)
                begin
                    frac_next = kvts_pkg::FRAC_ZERO;
                end
                else
                begin
                    frac_next = kvts_pkg::FRAC_ONE;
                end
            end
            kvts_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    frac_next = {1'b0, div_quotient};
                end
            end
            kvts_pkg::ST_MUL:
            begin
                prod_next = mul_d * $signed({1'b0, frac_reg});
            end
            kvts_pkg::ST_ACC:
            begin
                res_next[comp_reg] = acc_sum[kvts_pkg::DATA_W-1:0];
                comp_next          = comp_reg + 2'd1;
            end
            kvts_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = res_reg[0];
                    out_y_next     = res_reg[1];
                    out_z_next     = res_reg[2];
                    out_seg_next   = seg_ext[kvts_pkg::IDX_FLD_W-1:0];
                end
            end
            default:
            begin
                t_next = t_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kvts_pkg::ST_IDLE;
            key_count_reg <= kvts_pkg::CNT_FLD_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_count_reg <= key_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg       <= t_next;
        n_reg       <= n_next;
        low_reg     <= low_next;
        high_reg    <= high_next;
        mid_reg     <= mid_next;
        seg_reg     <= seg_next;
        t0_reg      <= t0_next;
        s_reg       <= s_next;
        d_reg       <= d_next;
        res_reg     <= res_next;
        frac_reg    <= frac_next;
        comp_reg    <= comp_next;
        prod_reg    <= prod_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_z_reg   <= out_z_next;
        out_seg_reg <= out_seg_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.out_x   = out_x_reg;
    assign rsp.out_y   = out_y_reg;
    assign rsp.out_z   = out_z_reg;
    assign rsp.segment = out_seg_reg;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for the keyframe track sampler
// Loads keyframe tables, samples them at chosen times and compares every
// interpolated point against a local model of the segment search and blend.
// ============================================================================

module tb;

    // This settle time covers the longest sample.
    localparam int SETTLE_CYCLES = 64;
    // Ends a hung run. A correct run takes a few milliseconds at worst.
    localparam longint WATCHDOG_NS = 64'd12_000_000;
    localparam int REPORT_LIMIT  = 10;

    // One item on the request channel.
    typedef struct packed {
        logic                           func;
        logic [kvts_pkg::IDX_FLD_W-1:0] key_index;
        kvts_pkg::key_t                 key;
        logic [kvts_pkg::DATA_W-1:0]    sample_time;
    } track_item_t;

    // One interpolated point on the response channel.
    typedef struct packed {
        logic signed [kvts_pkg::DATA_W-1:0] x;
        logic signed [kvts_pkg::DATA_W-1:0] y;
        logic signed [kvts_pkg::DATA_W-1:0] z;
        logic [kvts_pkg::IDX_FLD_W-1:0]     segment;
    } track_point_t;

    typedef logic [kvts_pkg::CNT_FLD_W-1:0] count_t;
    typedef logic [kvts_pkg::DATA_W-1:0]    word_t;

    // Ways the result side takes results.
    typedef enum int {SINK_OPEN, SINK_COIN, SINK_RUNS} sink_mode_t;

    logic   clk;
    logic   rst_n;
    logic   cfg_wr_en;
    count_t cfg_wr_data;

    kvts_req_if req_ch ();
    kvts_rsp_if rsp_ch ();

    keyframe_vec3_track_sampler_unit dut (
        .clk         (clk),
        .rsp         (rsp_ch),
        .req         (req_ch),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Local copy of the track: the key table and the key count register.
    kvts_pkg::key_t track_keys [kvts_pkg::MAX_KEYS];
    count_t         count_reg = count_t'(1);

    // Points that the block still owes, oldest first.
    track_point_t due_points [$];
    int           fail_count = 0;

    // Sender and receiver pacing, changed only while the block is idle.
    bit         gaps_on         = 0;
    int         burst_left      = 0;
    int         hold_off_cycles = 0;
    sink_mode_t sink_mode       = SINK_OPEN;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        #(WATCHDOG_NS);
        $display("FAIL keyframe_vec3_track_sampler_unit");
        $finish;
    end

    // ------------------------------------------------------------------
    // Track model
    // ------------------------------------------------------------------

    // A count of zero behaves as one key, and anything above the table
    // size behaves as a full table.
    function automatic int keys_in_use();
        if (count_reg == '0)
            return 1;
        if (int'(count_reg) > kvts_pkg::MAX_KEYS)
            return kvts_pkg::MAX_KEYS;
        return int'(count_reg);
    endfunction

    // Times at or before the first key pick the first segment, times at or after
    // the last key pick the last one, and everything else is found by a
    // binary search that stops at the first probe whose segment holds t.
    function automatic int locate_segment(int n, word_t t);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = n - 1;
        if (t <= track_keys[0].time_val)
            return 0;
        if (t >= track_keys[n-1].time_val)
            return n - 2;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (track_keys[mid].time_val <= t)
            begin
                if (t < track_keys[mid+1].time_val)
                    return mid;
                lo = mid + 1;
            end
            else
                hi = mid - 1;
        end
        return 0;
    endfunction

    // start + floor(f * (end - start) / 1.0), done exactly in 64 bits.
    // An arithmetic shift of the signed product gives the floor.
    function automatic word_t blend(logic signed [kvts_pkg::DATA_W-1:0] a,
                                    logic signed [kvts_pkg::DATA_W-1:0] b,
                                    logic [kvts_pkg::FRAC_W-1:0] frac);
        longint sa;
        longint sb;
        longint fl;
        longint prod;
        sa   = a;
        sb   = b;
        fl   = longint'(frac);
        prod = (sb - sa) * fl;
        return kvts_pkg::DATA_W'(sa + (prod >>> kvts_pkg::FRAC_BITS));
    endfunction

    function automatic track_point_t sample_track(word_t t);
        track_point_t                pt;
        int                          n;
        int                          seg;
        word_t                       t0;
        word_t                       t1;
        word_t                       diff;
        word_t                       span;
        logic [47:0]                 num;
        logic [47:0]                 quo;
        logic [kvts_pkg::FRAC_W-1:0] frac;
        n = keys_in_use();
        if (n == 1)
        begin
            pt.x       = track_keys[0].x;
            pt.y       = track_keys[0].y;
            pt.z       = track_keys[0].z;
            pt.segment = '0;
            return pt;
        end
        seg = locate_segment(n, t);
        t0  = track_keys[seg].time_val;
        t1  = track_keys[seg+1].time_val;
        // Clamping before the divide also covers zero-length and reversed
        // segments, so the divisor is never zero.
        if (t <= t0)
            frac = kvts_pkg::FRAC_ZERO;
        else if (t >= t1)
            frac = kvts_pkg::FRAC_ONE;
        else
        begin
            diff = t - t0;
            span = t1 - t0;
            num  = 48'(diff) << kvts_pkg::FRAC_BITS;
            quo  = num / 48'(span);
            frac = (quo > 48'(kvts_pkg::FRAC_ONE)) ? kvts_pkg::FRAC_ONE
                                                   : quo[kvts_pkg::FRAC_W-1:0];
        end
        pt.x       = blend(track_keys[seg].x, track_keys[seg+1].x, frac);
        pt.y       = blend(track_keys[seg].y, track_keys[seg+1].y, frac);
        pt.z       = blend(track_keys[seg].z, track_keys[seg+1].z, frac);
        pt.segment = kvts_pkg::IDX_FLD_W'(seg);
        return pt;
    endfunction

    // Called at the edge where the block accepts an item.
    function automatic void predict_item(track_item_t item);
        if (item.func == kvts_pkg::FUNC_LOAD)
            track_keys[item.key_index] = item.key;
        else
            due_points.insert(due_points.size(), sample_track(item.sample_time));
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------

    // Mostly random words, with the signed extremes, zero and minus one
    // showing up often enough to matter.
    function automatic word_t random_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic track_item_t load_item(int idx, word_t t, word_t x,
                                              word_t y, word_t z);
        track_item_t item;
        item.func         = kvts_pkg::FUNC_LOAD;
        item.key_index    = kvts_pkg::IDX_FLD_W'(idx);
        item.key.time_val = t;
        item.key.x        = x;
        item.key.y        = y;
        item.key.z        = z;
        item.sample_time  = $urandom;
        return item;
    endfunction

    // The key fields of a sample item are ignored, so they carry noise.
    function automatic track_item_t sample_item(word_t t);
        track_item_t item;
        item.func         = kvts_pkg::FUNC_SAMPLE;
        item.key_index    = kvts_pkg::IDX_FLD_W'($urandom);
        item.key.time_val = $urandom;
        item.key.x        = $urandom;
        item.key.y        = $urandom;
        item.key.z        = $urandom;
        item.sample_time  = t;
        return item;
    endfunction

    // Sample times: mostly inside one segment of the current track, and
    // also exactly on keys, at both ends of the time axis and anywhere.
    function automatic word_t pick_sample_time();
        int n;
        int seg;
        n = keys_in_use();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return track_keys[$urandom_range(0, n - 1)].time_val;
            3: return $urandom;
            default:
            begin
                if (n == 1)
                    return $urandom;
                seg = $urandom_range(0, n - 2);
                return $urandom_range(track_keys[seg+1].time_val,
                                      track_keys[seg].time_val);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Entered and left just after a falling edge. Valid stays high from one
    // item to the next within a burst; between bursts it drops for a while.
    task automatic send_item(input track_item_t item);
        req_ch.valid       = 1'b1;
        req_ch.func        = item.func;
        req_ch.key_index   = item.key_index;
        req_ch.key_time    = item.key.time_val;
        req_ch.key_x       = item.key.x;
        req_ch.key_y       = item.key.y;
        req_ch.key_z       = item.key.z;
        req_ch.sample_time = item.sample_time;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predict_item(item);
        @(negedge clk);
        if (gaps_on)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                req_ch.valid = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // Stops offering items and waits for every owed point, then lets a
    // trailing load item or a late sample settle inside the block.
    task automatic wait_track_idle();
        req_ch.valid = 1'b0;
        while (due_points.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_key_count(input count_t count);
        wait_track_idle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = count;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        cfg_wr_data = count_t'($urandom);
        count_reg   = count;
    endtask

    // Result side. A long hold-off, when one is asked for, is counted down
    // here and wins over the normal pattern.
    initial
    begin : result_ready
        int run_left;
        run_left     = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold_off_cycles--;
            end
            else
            begin
                case (sink_mode)
                    SINK_OPEN:
                        rsp_ch.ready = 1'b1;
                    SINK_COIN:
                        rsp_ch.ready = 1'($urandom_range(0, 1));
                    default:
                    begin
                        // Alternating runs of ready and stall cycles.
                        if (run_left == 0)
                        begin
                            rsp_ch.ready = ~rsp_ch.ready;
                            run_left = rsp_ch.ready ? $urandom_range(1, 8)
                                                    : $urandom_range(1, 20);
                        end
                        else
                            run_left--;
                    end
                endcase
            end
        end
    end

    // Every accepted point is matched against the oldest owed one.
    initial
    begin : point_check
        track_point_t got;
        track_point_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.x       = rsp_ch.out_x;
                got.y       = rsp_ch.out_y;
                got.z       = rsp_ch.out_z;
                got.segment = rsp_ch.segment;
                if (due_points.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected point: x=%h y=%h z=%h seg=%0d",
                                 got.x, got.y, got.z, got.segment);
                end
                else
                begin
                    want = due_points.pop_front();
                    if (got.x !== want.x || got.y !== want.y ||
                        got.z !== want.z || got.segment !== want.segment)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"point mismatch: want x=%h y=%h z=%h seg=%0d,",
                                      " got x=%h y=%h z=%h seg=%0d"},
                                     want.x, want.y, want.z, want.segment,
                                     got.x, got.y, got.z, got.segment);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // After reset one key is in use, so a sample returns key 0 as it is.
    // A key count of zero must behave the same way. The top slot is loaded
    // too, so every index bit is set once.
    task automatic test_single_key();
        sink_mode = SINK_COIN;
        gaps_on   = 1;
        send_item(load_item(0, '1, 32'h8000_0000, 32'h7FFF_FFFF, '1));
        send_item(load_item(kvts_pkg::MAX_KEYS - 1, '0, '0, '0, '0));
        send_item(sample_item('0));
        send_item(sample_item('1));
        set_key_count(count_t'(0));
        send_item(sample_item(32'h1234_5678));
    endtask

    // Two keys with full-swing values: before, on and after each key, a
    // time that gives a fraction just under one half, then a zero-length
    // segment and a reversed one.
    task automatic test_two_key_edges();
        set_key_count(count_t'(2));
        send_item(load_item(0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, '0));
        send_item(load_item(1, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'hFFFF_FFFB));
        send_item(sample_item('0));
        send_item(sample_item(32'h0001_0000));
        send_item(sample_item(32'h0001_FFFF));
        send_item(sample_item(32'h0003_0000));
        send_item(sample_item('1));
        // Both keys at the same time: past it the fraction is a full one.
        send_item(load_item(1, 32'h0001_0000, 32'h0000_1000, 32'hFFFF_0000, '1));
        send_item(sample_item(32'h0001_0001));
        // Second key earlier than the first.
        send_item(load_item(1, 32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000, '0));
        send_item(sample_item(32'h0000_9000));
        send_item(sample_item(32'h0002_0000));
    endtask

    // Keys out of order: the search still has to land where the block
    // lands, and the fraction may clamp to either end.
    task automatic test_unsorted_keys();
        set_key_count(count_t'(4));
        send_item(load_item(0, 32'h0000_0100, random_value(), random_value(),
                            random_value()));
        send_item(load_item(1, 32'h0000_0900, random_value(), random_value(),
                            random_value()));
        send_item(load_item(2, 32'h0000_0200, random_value(), random_value(),
                            random_value()));
        send_item(load_item(3, 32'h0000_1000, random_value(), random_value(),
                            random_value()));
        send_item(sample_item(32'h0000_0500));
        send_item(sample_item(32'h0000_0950));
        send_item(sample_item(32'h0000_0C00));
        send_item(sample_item(32'h0000_1000));
    endtask

    // A full track load in ascending time order with random values and
    // one of three time scales, then mostly samples, with some reloads
    // that keep the order and some stray loads that may break it.
    task automatic test_random_track(input count_t count,
                                     input int items,
                                     input sink_mode_t mode,
                                     input bit gapped);
        int     n;
        int     idx;
        int     k;
        longint stamp;
        longint step_max;
        word_t  lo;
        word_t  hi;
        set_key_count(count);
        sink_mode = mode;
        gaps_on   = gapped;
        n         = keys_in_use();
        case ($urandom_range(0, 2))
            0:       step_max = 16;
            1:       step_max = 1 << 18;
            default: step_max = 64'hFFFF_FFFF / n;
        endcase
        stamp = (step_max > 16) ? longint'($urandom_range(0, 1 << 20))
                                : longint'($urandom);
        for (idx = 0; idx < n; idx++)
        begin
            send_item(load_item(idx, stamp[kvts_pkg::DATA_W-1:0], random_value(),
                                random_value(), random_value()));
            // A zero step now and then gives a zero-length segment.
            stamp += $urandom_range(0, 32'(step_max));
            if (stamp > 64'hFFFF_FFFF)
                stamp = 64'hFFFF_FFFF;
        end
        for (k = 0; k < items; k++)
        begin
            case ($urandom_range(0, 19)) inside
                [0:14]:
                    send_item(sample_item(pick_sample_time()));
                [15:17]:
                begin
                    idx = $urandom_range(0, n - 1);
                    lo  = (idx == 0) ? '0 : track_keys[idx-1].time_val;
                    hi  = (idx == n - 1) ? '1 : track_keys[idx+1].time_val;
                    send_item(load_item(idx, $urandom_range(hi, lo),
                                        random_value(), random_value(),
                                        random_value()));
                end
                default:
                    send_item(load_item($urandom_range(0, kvts_pkg::MAX_KEYS - 1),
                                        $urandom, random_value(),
                                        random_value(), random_value()));
            endcase
        end
    endtask

    // The result side holds off for a long stretch while samples keep
    // coming back to back, so the block fills and stalls its input. The
    // sender waits for every owed point; a gapped run with stalls follows.
    task automatic test_backpressure();
        int k;
        wait_track_idle();
        sink_mode       = SINK_OPEN;
        gaps_on         = 0;
        hold_off_cycles = 400;
        for (k = 0; k < 30; k++)
            send_item(sample_item(pick_sample_time()));
        wait_track_idle();
        sink_mode = SINK_RUNS;
        gaps_on   = 1;
        for (k = 0; k < 10; k++)
            send_item(sample_item(pick_sample_time()));
        wait_track_idle();
    endtask

    initial
    begin : run_tests
        // Every input is known from time zero.
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        req_ch.valid       = 1'b0;
        req_ch.func        = kvts_pkg::FUNC_LOAD;
        req_ch.key_index   = '0;
        req_ch.key_time    = '0;
        req_ch.key_x       = '0;
        req_ch.key_y       = '0;
        req_ch.key_z       = '0;
        req_ch.sample_time = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_single_key();
        test_two_key_edges();
        test_unsorted_keys();

        // Settings run from a full table past its top, through the
        // smallest tracks, to zero and one and a random size.
        test_random_track(count_t'(64), 300, SINK_OPEN, 0);
        test_backpressure();
        test_random_track(count_t'(127), 250, SINK_RUNS, 1);
        test_random_track(count_t'(2), 200, SINK_COIN, 1);
        test_random_track(count_t'(3), 200, SINK_RUNS, 0);
        test_random_track(count_t'($urandom_range(4, kvts_pkg::MAX_KEYS - 1)), 250,
                          SINK_COIN, 0);
        test_random_track(count_t'(0), 100, SINK_OPEN, 1);
        test_random_track(count_t'(1), 100, SINK_RUNS, 1);
        test_random_track(count_t'($urandom_range(1, 127)), 250,
                          sink_mode_t'($urandom_range(0, 2)),
                          1'($urandom_range(0, 1)));

        wait_track_idle();
        if (fail_count == 0 && due_points.size() == 0)
            $display("PASS keyframe_vec3_track_sampler_unit");
        else
            $display("FAIL keyframe_vec3_track_sampler_unit");
        $finish;
    end

endmodule

// ===== keyframe_vec3_track_sampler_unit.f =====
rtl/kvts_pkg.sv
rtl/kvts_ifs.sv
rtl/kvts_key_mem.sv
rtl/kvts_frac_div.sv
rtl/keyframe_vec3_track_sampler_unit.sv
tb/tb.sv
